// ----- rtl/core/tdlcd_pkg.sv -----
package tdlcd_pkg;

  localparam int NUM_COMS  = 4;
  localparam int COM_W     = 2;
  localparam int ROW_W     = 8;
  localparam int VALUE_W   = 16;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 16;

  localparam logic [ROW_W-1:0]   ROW_MARKER   = 8'h0a;
  localparam logic [ROW_W-1:0]   ROW_MINUS    = 8'h20;
  localparam logic [ROW_W-1:0]   ROW_OVERFLOW = 8'h2a;
  localparam logic [VALUE_W-1:0] MAX_SHOWN    = 16'd99;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef logic [ROW_W-1:0] row_t;
  typedef row_t [NUM_COMS-1:0] rows_t;

  // one processed word handed to the scan stage
  typedef struct packed {
    logic fire;
    logic load;
  } step_t;

  function automatic row_t glyph(input logic [3:0] digit);
    row_t g;
    unique case (digit)
      4'd0:    g = 8'h77;
      4'd1:    g = 8'h14;
      4'd2:    g = 8'h5b;
      4'd3:    g = 8'h5d;
      4'd4:    g = 8'h3c;
      4'd5:    g = 8'h6d;
      4'd6:    g = 8'h6f;
      4'd7:    g = 8'h54;
      4'd8:    g = 8'h7f;
      4'd9:    g = 8'h7d;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

// ----- rtl/core/two_digit_lcd_mux_driver.sv -----
// two-digit multiplexed segment lcd driver, four commons, half bias
// input stream: in_tuser selects the word kind (load number or phase tick),
//   in_tdata carries the signed 16-bit value, read on a load only
// output stream: one word per input word with the segment port byte,
//   the common line levels and the push-pull drive mask of the commons
// a load rebuilds the four segment rows and restarts the scan at common 0,
//   direct phase; a tick steps to the next phase (direct, inverted, next com)
// an accepted input word passes the input register, then row decode and
//   scan update into the output register
// throughput: one word per cycle while the receiver keeps taking words, set by the single decode stage
// reset: rows show only the marker, scan at common 0 direct phase, both
//   stages empty
// when the receiver stalls the output register holds its word, the input
//   register still takes one more word, then in_tready drops
module two_digit_lcd_mux_driver (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tdlcd_pkg::IN_DATA_W-1:0]     in_tdata,   // value[15:0]
  input  logic                                in_tuser,   // kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tdlcd_pkg::OUT_DATA_W-1:0]    out_tdata   // seg_pins, com_levels, com_drive_mask
);

  logic                                  in_valid_r, in_valid_nxt;
  logic                                  kind_r;
  logic signed [tdlcd_pkg::VALUE_W-1:0]  value_r;
  logic                                  out_free;
  tdlcd_pkg::step_t                      step;
  tdlcd_pkg::rows_t                      rows_new;

  assign in_tready    = !in_valid_r || out_free;
  assign step.fire    = in_valid_r && out_free;
  assign step.load    = kind_r == tdlcd_pkg::KIND_LOAD;
  assign in_valid_nxt = (in_tvalid && in_tready) || (in_valid_r && !out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
    if (in_tvalid && in_tready) begin
      kind_r  <= in_tuser;
      value_r <= $signed(in_tdata[tdlcd_pkg::VALUE_W-1:0]);
    end
  end

  tdlcd_row_enc u_row_enc (
    .value (value_r),
    .rows  (rows_new)
  );

  tdlcd_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .rows_new   (rows_new),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- rtl/core/tdlcd_row_enc.sv -----
module tdlcd_row_enc (
  input  logic signed [tdlcd_pkg::VALUE_W-1:0] value,
  output tdlcd_pkg::rows_t                     rows
);

  logic                            neg;
  logic [tdlcd_pkg::VALUE_W-1:0]   mag;
  logic                            ovf;
  logic [6:0]                      mag7;
  logic [14:0]                     prod;
  logic [3:0]                      tens;
  logic [6:0]                      tens_x10;
  logic [3:0]                      units;
  tdlcd_pkg::row_t                 t_g;
  tdlcd_pkg::row_t                 u_g;

  always_comb begin
    neg      = value[tdlcd_pkg::VALUE_W-1];
    mag      = neg ? tdlcd_pkg::VALUE_W'(-value) : tdlcd_pkg::VALUE_W'(value);
    ovf      = mag > tdlcd_pkg::MAX_SHOWN;
    mag7     = mag[6:0];
    // divide by ten via reciprocal, exact for every 7-bit input
    prod     = 15'(mag7) * 15'd205;
    tens     = prod[14:11];
    tens_x10 = 7'(tens) * 7'd10;
    units    = 4'(mag7 - tens_x10);
    t_g      = tdlcd_pkg::glyph(tens);
    u_g      = tdlcd_pkg::glyph(units);

    if (ovf) begin
      rows[0] = '0;
      rows[1] = '0;
      rows[2] = '0;
      rows[3] = tdlcd_pkg::ROW_OVERFLOW;
    end else begin
      rows[0] = {4'b0, t_g[1:0], u_g[1:0]};
      rows[1] = {4'b0, t_g[3:2], u_g[3:2]} | (neg ? tdlcd_pkg::ROW_MINUS : 8'h00);
      rows[2] = {4'b0, t_g[5:4], u_g[5:4]};
      rows[3] = {4'b0, t_g[7:6], u_g[7:6]} | tdlcd_pkg::ROW_MARKER;
    end
  end

endmodule

// ----- rtl/core/tdlcd_scan.sv -----
module tdlcd_scan (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tdlcd_pkg::step_t                    step,
  input  tdlcd_pkg::rows_t                    rows_new,
  output logic                                out_free,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tdlcd_pkg::OUT_DATA_W-1:0]    out_tdata
);

  tdlcd_pkg::rows_t                   rows_r,  rows_nxt;
  logic [tdlcd_pkg::COM_W-1:0]        idx_r,   idx_nxt;
  logic                               ph_r,    ph_nxt;
  logic                               valid_r, valid_nxt;
  logic [tdlcd_pkg::OUT_DATA_W-1:0]   data_r,  data_nxt;
  logic [tdlcd_pkg::NUM_COMS-1:0]     onehot;
  tdlcd_pkg::row_t                    row;

  assign out_free   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

  always_comb begin
    rows_nxt  = rows_r;
    idx_nxt   = idx_r;
    ph_nxt    = ph_r;
    valid_nxt = valid_r && !out_tready;
    if (step.fire) begin
      valid_nxt = 1'b1;
      if (step.load) begin
        rows_nxt = rows_new;
        idx_nxt  = '0;
        ph_nxt   = 1'b0;
      end else if (!ph_r) begin
        ph_nxt = 1'b1;
      end else begin
        ph_nxt  = 1'b0;
        idx_nxt = idx_r + 1'b1;
      end
    end
    onehot = tdlcd_pkg::NUM_COMS'(1) << idx_nxt;
    row    = rows_nxt[idx_nxt];
    if (ph_nxt) begin
      data_nxt = {onehot, onehot, ~row};
    end else begin
      data_nxt = {onehot, ~onehot, row};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= {tdlcd_pkg::ROW_MARKER, 8'h00, 8'h00, 8'h00};
      idx_r   <= '0;
      ph_r    <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      rows_r  <= rows_nxt;
      idx_r   <= idx_nxt;
      ph_r    <= ph_nxt;
      valid_r <= valid_nxt;
    end
    if (step.fire) begin
      data_r <= data_nxt;
    end
  end

  a_mask_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> $onehot(data_r[15:12]))
    else $error("drive mask not one-hot");

  a_levels_match_phase: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (data_r[11:8] == data_r[15:12]) || (data_r[11:8] == ~data_r[15:12]))
    else $error("common levels inconsistent with drive mask");

  a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    step.fire && step.load |=> idx_r == '0 && !ph_r && data_r[11:8] == 4'b1110)
    else $error("load did not restart scan");

  a_tick_direct_to_inv: assert property (@(posedge clk) disable iff (!rst_n)
    step.fire && !step.load && !ph_r |=> ph_r && idx_r == $past(idx_r))
    else $error("tick from direct phase moved common");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_tready && !step.fire |=> valid_r && $stable(data_r))
    else $error("stalled word lost");

endmodule

// ----- sim/two_digit_lcd_mux_driver_tb.sv -----
`timescale 1ns / 100ps

module two_digit_lcd_mux_driver_tb;

  localparam int CLK_HALF    = 2;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 20;

  // seg_pins lowest, then com_levels, then com_drive_mask
  typedef struct packed {
    logic [3:0] drive;
    logic [3:0] levels;
    logic [7:0] seg;
  } lcd_pins_t;

  localparam logic [7:0] DIGIT_GLYPH [10] = '{
    8'h77, 8'h14, 8'h5b, 8'h5d, 8'h3c, 8'h6d, 8'h6f, 8'h54, 8'h7f, 8'h7d
  };

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [tdlcd_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                             in_tuser;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [tdlcd_pkg::OUT_DATA_W-1:0] out_tdata;

  tdlcd_pkg::rows_t lcd_rows;
  logic [1:0]       scan_com;
  logic             scan_inverted;
  lcd_pins_t        pin_queue[$];

  int          send_idle_pct;
  int          recv_idle_pct;
  int          err_count   = 0;
  int          cycle_count = 0;

  two_digit_lcd_mux_driver u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("two_digit_lcd_mux_driver_tb: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // rebuild rows from a signed number
  function automatic tdlcd_pkg::rows_t encode_number(input logic signed [15:0] num);
    tdlcd_pkg::rows_t r;
    int               mag;
    logic [7:0]       t;
    logic [7:0]       u;
    mag = (num < 0) ? -int'(num) : int'(num);
    r[0] = '0;
    r[1] = (num < 0) ? tdlcd_pkg::ROW_MINUS : '0;
    r[2] = '0;
    r[3] = tdlcd_pkg::ROW_MARKER;
    if (mag > int'(tdlcd_pkg::MAX_SHOWN)) begin
      r[0] = '0;
      r[1] = '0;
      r[2] = '0;
      r[3] = tdlcd_pkg::ROW_OVERFLOW;
    end else begin
      t = DIGIT_GLYPH[mag / 10];
      u = DIGIT_GLYPH[mag % 10];
      r[0] = r[0] | ((t & 8'h03) << 2) | (u & 8'h03);
      r[1] = r[1] | (t & 8'h0c) | ((u & 8'h0c) >> 2);
      r[2] = r[2] | ((t & 8'h30) >> 2) | ((u & 8'h30) >> 4);
      r[3] = r[3] | ((t & 8'hc0) >> 4) | ((u & 8'hc0) >> 6);
    end
    return r;
  endfunction

  // advance the scan model by one word and queue the pins it should show
  task automatic predict_pins(input logic kind, input logic [15:0] value);
    lcd_pins_t  p;
    logic [3:0] onehot;
    if (kind == tdlcd_pkg::KIND_LOAD) begin
      lcd_rows      = encode_number(value);
      scan_com      = '0;
      scan_inverted = 1'b0;
    end else if (!scan_inverted) begin
      scan_inverted = 1'b1;
    end else begin
      scan_inverted = 1'b0;
      scan_com      = scan_com + 2'd1;
    end
    onehot  = 4'b0001 << scan_com;
    p.drive = onehot;
    if (!scan_inverted) begin
      p.seg    = lcd_rows[scan_com];
      p.levels = ~onehot;
    end else begin
      p.seg    = ~lcd_rows[scan_com];
      p.levels = onehot;
    end
    pin_queue.push_back(p);
  endtask

  task automatic send_word(input logic kind, input logic [15:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pins(kind, value);
  endtask

  always @(posedge clk) begin
    lcd_pins_t want;
    lcd_pins_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pin_queue.size() == 0) begin
        $error("unexpected word: %h", out_tdata);
        err_count++;
      end else begin
        want = pin_queue.pop_front();
        if (got.seg !== want.seg) begin
          $error("seg_pins: expected %h, got %h", want.seg, got.seg);
          err_count++;
        end
        if (got.levels !== want.levels) begin
          $error("com_levels: expected %h, got %h", want.levels, got.levels);
          err_count++;
        end
        if (got.drive !== want.drive) begin
          $error("com_drive_mask: expected %h, got %h", want.drive, got.drive);
          err_count++;
        end
      end
    end
  end

  function automatic logic [15:0] pick_number();
    int r;
    logic [15:0] edges [6] = '{16'd99, -16'sd99, 16'd100, -16'sd100, 16'h8000, 16'h7fff};
    r = $urandom_range(99);
    if (r < 70) return 16'($signed($urandom_range(198)) - 99);
    if (r < 85) return edges[$urandom_range(5)];
    return 16'($urandom);
  endfunction

  // marker-only rows through a full scan, including the wrap back to common 0
  task automatic test_reset_scan();
    repeat (9) send_word(tdlcd_pkg::KIND_TICK, 16'($urandom));
  endtask

  task automatic test_number_encoding();
    logic [15:0] nums [10] = '{-16'sd7, 16'd38, 16'd99, -16'sd99, 16'd100,
                               -16'sd100, 16'h8000, 16'h7fff, 16'd0, 16'hffff};
    foreach (nums[i]) begin
      send_word(tdlcd_pkg::KIND_LOAD, nums[i]);
      if (i < 4) send_word(tdlcd_pkg::KIND_TICK, 16'($urandom));
    end
  endtask

  // load followed by a run of ticks, with some stray loads mixed in
  task automatic test_random_traffic(input int n_words);
    int sent;
    int ticks;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(99) < 10) begin
        send_word(tdlcd_pkg::KIND_LOAD, 16'($urandom));
        sent++;
      end else begin
        send_word(tdlcd_pkg::KIND_LOAD, pick_number());
        ticks = $urandom_range(16);
        repeat (ticks) send_word(tdlcd_pkg::KIND_TICK, 16'($urandom));
        sent += ticks + 1;
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = tdlcd_pkg::KIND_LOAD;
    send_idle_pct = 11;
    recv_idle_pct = 72;
    lcd_rows      = '{tdlcd_pkg::ROW_MARKER, 8'h00, 8'h00, 8'h00};
    scan_com      = '0;
    scan_inverted = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_scan();
    test_number_encoding();
    test_random_traffic(530);
    send_idle_pct = 72;
    recv_idle_pct = 11;
    test_random_traffic(530);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(530);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pin_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("two_digit_lcd_mux_driver_tb: clean");
    end else begin
      $display("two_digit_lcd_mux_driver_tb: errors");
    end
    $finish;
  end

endmodule

// ----- two_digit_lcd_mux_driver.f -----
rtl/core/tdlcd_pkg.sv
rtl/core/tdlcd_row_enc.sv
rtl/core/tdlcd_scan.sv
rtl/core/two_digit_lcd_mux_driver.sv
sim/two_digit_lcd_mux_driver_tb.sv
